[hdl/tpsd_pkg.sv]
// Shared constants, widths and the quarter-wave sine table for the three-phase sine drive.
// The table is built at elaboration by an integer Taylor series; no other file is required.
`default_nettype none

package tpsd_pkg;

    // Angle resolution: one quarter turn in table steps.
    localparam int QUARTER_STEPS = 900;
    localparam int SINE_DEPTH    = QUARTER_STEPS + 1;
    localparam int PERIOD        = 4 * QUARTER_STEPS;

    // Field widths.
    localparam int ANGLE_W = 15;
    localparam int POWER_W = 16;
    localparam int PHASE_W = 17;
    localparam int SINE_W  = 15;

    // Phase spacing between neighboring outputs, in angle units.
    localparam int PHASE_OFFSET = 600;

    // Internal widths of the angle path.
    localparam int SUM_W     = ANGLE_W + 2;
    localparam int MAG_W     = SUM_W - 1;
    localparam int MAG_MAX   = (1 << (ANGLE_W - 1)) + PHASE_OFFSET;
    localparam int MOD_STEPS = $clog2(MAG_MAX / PERIOD + 1);
    localparam int RED_W     = $clog2(PERIOD);
    localparam int IDX_W     = $clog2(SINE_DEPTH);

    // Product and scaling.
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = POWER_W + SINE_W;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = ((ANGLE_W + POWER_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * PHASE_W + 7) / 8) * 8;

    // Number of phase lanes.
    localparam int LANES = 3;

    typedef logic [SINE_DEPTH-1:0][SINE_W-1:0] t_sine_rom;

    // pi/2 in Q62.
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] SINE_SCALE  = 64'd3276749;

    // Angle step of one table entry in Q62: whole part and remainder over QUARTER_STEPS.
    localparam logic [63:0] X_STEP = HALF_PI_Q62 / 64'(QUARTER_STEPS);
    localparam logic [63:0] X_REM  = HALF_PI_Q62 % 64'(QUARTER_STEPS);

    // Q62 by Q62 product, truncated back to Q62.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Unsigned 64-bit quotient by restoring long division.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // One table entry: trunc(32767.49 * sin(i * pi / (2 * QUARTER_STEPS))).
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  sum_v;
        logic [63:0]  term;
        logic [63:0]  divk;
        logic [63:0]  v;
        logic [127:0] w;
        x = X_STEP * 64'(i) + udiv64(X_REM * 64'(i), 64'(QUARTER_STEPS));
        x2    = mul_q62(x, x);
        sum_v = x;
        term  = x;
        // Taylor series of the sine, fourteen terms past the first.
        for (int k = 1; k <= 14; k++) begin
            divk = 64'((2 * k) * (2 * k + 1));
            term = udiv64(mul_q62(term, x2), divk);
            if ((k % 2) == 1) begin
                sum_v = sum_v - term;
            end else begin
                sum_v = sum_v + term;
            end
        end
        w = {64'd0, sum_v} * {64'd0, SINE_SCALE};
        v = udiv64(w[125:62], 64'd100);
        if (v > 64'((1 << SINE_W) - 1)) begin
            v = 64'((1 << SINE_W) - 1);
        end
        return v[SINE_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    // Quarter-wave sine ROM contents.
    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

[hdl/three_phase_sine_drive_top.sv]
// Three-phase sine drive: angle and power in, three scaled phase values out.
// Depends on tpsd_pkg for widths, the phase offset and the quarter-wave sine ROM.
`default_nettype none

// Usage
// The slave stream carries one transfer per drive update: an angle in tenths
// of a degree (3600 per turn, signed) and an unsigned power level. For each
// transfer the master stream carries one transfer with the three phase values
// for angle+600, angle and angle-600, each power * sine >> 15, rounded toward
// minus infinity.
// Throughput is one transfer per cycle while the receiver keeps up; the three
// sine lookups per item are three parallel reads of the constant ROM, all in
// the same cycle.
// Each of the six stages has its own valid bit and moves when the stage after
// it is empty or moving, so a stalled receiver only backs up the pipeline as
// far as it is full; new input is taken while bubbles remain. The output
// register holds its value until the receiver takes it.
// Reset clears the stage valid bits only. The sine table is a constant ROM
// and needs no load or clearing pass after reset.
module three_phase_sine_drive_top import tpsd_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Fields from bit 0: angle[14:0], power[30:15], zero pad [31].
    input  wire  [IN_DATA_W-1:0]   s_axis_tdata,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: phase_a[16:0], phase_b[33:17], phase_c[50:34], zero pad above.
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready
);

    localparam int STAGES = 6;

    // Stage valid bits and per-stage move enables.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_go;

    // Stage 0: offset angles.
    logic signed [SUM_W-1:0] r_sum [LANES];
    logic [POWER_W-1:0]      r_pow0;
    // Stage 1: reduced magnitudes and input sign.
    logic [RED_W-1:0]        r_red [LANES];
    logic [LANES-1:0]        r_sgn1;
    logic [POWER_W-1:0]      r_pow1;
    // Stage 2: ROM index and result sign.
    logic [IDX_W-1:0]        r_idx [LANES];
    logic [LANES-1:0]        r_sgn2;
    logic [POWER_W-1:0]      r_pow2;
    // Stage 3: sine magnitudes from the ROM.
    logic [SINE_W-1:0]       r_sin [LANES];
    logic [LANES-1:0]        r_sgn3;
    logic [POWER_W-1:0]      r_pow3;
    // Stage 4: unsigned products.
    logic [PROD_W-1:0]       r_prod [LANES];
    logic [LANES-1:0]        r_sgn4;
    // Stage 5: output phases.
    logic [PHASE_W-1:0]      r_phase [LANES];

    logic signed [SUM_W-1:0] n_sum [LANES];
    logic [RED_W-1:0]        n_red [LANES];
    logic [LANES-1:0]        n_sgn1;
    logic [IDX_W-1:0]        n_idx [LANES];
    logic [LANES-1:0]        n_sgn2;
    logic [PHASE_W-1:0]      n_phase [LANES];

    logic signed [ANGLE_W-1:0] w_angle;
    logic [POWER_W-1:0]        w_power;

    assign w_angle = $signed(s_axis_tdata[ANGLE_W-1:0]);
    assign w_power = s_axis_tdata[ANGLE_W+POWER_W-1:ANGLE_W];

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_go[STAGES-1] = !r_vld[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_go[k] = !r_vld[k] || w_go[k+1];
        end
    end

    assign s_axis_tready = w_go[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_go[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_go[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: form angle+offset, angle and angle-offset at full width.
    always_comb begin
        n_sum[0] = SUM_W'(w_angle) + SUM_W'(PHASE_OFFSET);
        n_sum[1] = SUM_W'(w_angle);
        n_sum[2] = SUM_W'(w_angle) - SUM_W'(PHASE_OFFSET);
    end

    // Stage 1: magnitude, then restoring reduction modulo one turn.
    always_comb begin
        logic [MAG_W:0] red_v;
        for (int p = 0; p < LANES; p++) begin
            n_sgn1[p] = r_sum[p][SUM_W-1];
            red_v = n_sgn1[p] ? {1'b0, MAG_W'(-r_sum[p])} : {1'b0, MAG_W'(r_sum[p])};
            for (int j = MOD_STEPS - 1; j >= 0; j--) begin
                if (red_v >= (MAG_W+1)'(PERIOD << j)) begin
                    red_v = red_v - (MAG_W+1)'(PERIOD << j);
                end
            end
            n_red[p] = red_v[RED_W-1:0];
        end
    end

    // Stage 2: fold into the first quadrant; the lower half-turn keeps the sign.
    always_comb begin
        for (int p = 0; p < LANES; p++) begin
            if (r_red[p] <= RED_W'(QUARTER_STEPS)) begin
                n_idx[p]  = IDX_W'(r_red[p]);
                n_sgn2[p] = r_sgn1[p];
            end else if (r_red[p] <= RED_W'(2 * QUARTER_STEPS)) begin
                n_idx[p]  = IDX_W'(RED_W'(2 * QUARTER_STEPS) - r_red[p]);
                n_sgn2[p] = r_sgn1[p];
            end else if (r_red[p] <= RED_W'(3 * QUARTER_STEPS)) begin
                n_idx[p]  = IDX_W'(r_red[p] - RED_W'(2 * QUARTER_STEPS));
                n_sgn2[p] = !r_sgn1[p];
            end else begin
                n_idx[p]  = IDX_W'(RED_W'(PERIOD) - r_red[p]);
                n_sgn2[p] = !r_sgn1[p];
            end
        end
    end

    // Stage 5: floor of the signed product over 2^15.
    always_comb begin
        logic [PROD_W:0] mag_v;
        for (int p = 0; p < LANES; p++) begin
            if (r_sgn4[p]) begin
                mag_v = ({1'b0, r_prod[p]} + (PROD_W+1)'((1 << FRAC_BITS) - 1)) >> FRAC_BITS;
                n_phase[p] = ~PHASE_W'(mag_v) + PHASE_W'(1);
            end else begin
                mag_v = {1'b0, r_prod[p]} >> FRAC_BITS;
                n_phase[p] = PHASE_W'(mag_v);
            end
        end
    end

    // Pipeline data registers; each stage loads when it moves.
    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r_sum  <= n_sum;
            r_pow0 <= w_power;
        end
        if (w_go[1]) begin
            r_red  <= n_red;
            r_sgn1 <= n_sgn1;
            r_pow1 <= r_pow0;
        end
        if (w_go[2]) begin
            r_idx  <= n_idx;
            r_sgn2 <= n_sgn2;
            r_pow2 <= r_pow1;
        end
        if (w_go[4]) begin
            for (int p = 0; p < LANES; p++) begin
                r_prod[p] <= PROD_W'(r_pow3 * r_sin[p]);
            end
            r_sgn4 <= r_sgn3;
        end
        if (w_go[5]) begin
            r_phase <= n_phase;
        end
    end

    // Stage 3: synchronous ROM reads, one per lane.
    always_ff @(posedge i_clk) begin
        if (w_go[3]) begin
            r_sin[0] <= SINE_ROM[r_idx[0]];
            r_sin[1] <= SINE_ROM[r_idx[1]];
            r_sin[2] <= SINE_ROM[r_idx[2]];
            r_sgn3   <= r_sgn2;
            r_pow3   <= r_pow2;
        end
    end

    // Output transfer.
    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = {(OUT_DATA_W - 3 * PHASE_W)'(0), r_phase[2], r_phase[1], r_phase[0]};

endmodule

`default_nettype wire

[tb/tb_three_phase_sine_drive_top.sv]
// Self-checking testbench for the three-phase sine drive: streams angle and power commands
// and compares every phase triplet with an in-bench prediction from its own quarter-wave sine.
// Depends on tpsd_pkg for field widths and angle constants, and on three_phase_sine_drive_top.
`timescale 1ns / 1ps

module tb_three_phase_sine_drive_top import tpsd_pkg::*; ();

    // One drive command as it enters the slave stream.
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [POWER_W-1:0] power;
    } drive_cmd_t;

    // The three phase values carried by one master-side transfer.
    typedef struct packed {
        logic [PHASE_W-1:0] phase_a;
        logic [PHASE_W-1:0] phase_b;
        logic [PHASE_W-1:0] phase_c;
    } phase_triplet_t;

    localparam logic [63:0] PI_OVER_TWO_Q62 = 64'h6487ED5110B4611A;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          RANDOM_CMDS     = 1600;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    logic [SINE_W-1:0] quarter_sine [0:QUARTER_STEPS];

    drive_cmd_t     cmd_queue[$];
    phase_triplet_t expected_phases[$];

    int unsigned mismatch_count = 0;
    int unsigned src_gap_left = 0;
    int unsigned sink_stall_left = 0;
    logic        src_steady = 1'b0;
    logic        sink_steady = 1'b0;

    three_phase_sine_drive_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #10 i_clk = ~i_clk;

    // Q62 fixed-point product, truncated back to Q62.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Quarter-wave entry: truncated 32767.49 * sin(i * pi / (2 * QUARTER_STEPS)).
    function automatic logic [SINE_W-1:0] quarter_sine_value(input int unsigned i);
        logic [63:0]  x;
        logic [63:0]  x_sq;
        logic [63:0]  acc;
        logic [63:0]  term;
        logic [63:0]  scaled;
        logic [127:0] wide;
        x = (PI_OVER_TWO_Q62 / 64'(QUARTER_STEPS)) * 64'(i)
            + ((PI_OVER_TWO_Q62 % 64'(QUARTER_STEPS)) * 64'(i)) / 64'(QUARTER_STEPS);
        x_sq = q62_mul(x, x);
        acc  = x;
        term = x;
        for (int k = 1; k <= 14; k++) begin
            term = q62_mul(term, x_sq) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        wide   = {64'd0, acc} * 128'd3276749;
        scaled = wide[125:62] / 64'd100;
        if (scaled > 64'd32767) begin
            scaled = 64'd32767;
        end
        return scaled[SINE_W-1:0];
    endfunction

    // Signed Q15 sine of an unwrapped angle, folded from the quarter wave.
    function automatic int signed angle_sine(input int signed ang);
        int signed mag;
        int signed val;
        logic      negative;
        negative = (ang < 0);
        mag = negative ? -ang : ang;
        mag = mag % PERIOD;
        if (mag <= QUARTER_STEPS) begin
            val = int'(quarter_sine[mag]);
        end else if (mag <= 2 * QUARTER_STEPS) begin
            val = int'(quarter_sine[2 * QUARTER_STEPS - mag]);
        end else if (mag <= 3 * QUARTER_STEPS) begin
            val = -int'(quarter_sine[mag - 2 * QUARTER_STEPS]);
        end else begin
            val = -int'(quarter_sine[PERIOD - mag]);
        end
        return negative ? -val : val;
    endfunction

    // Power times sine, shifted right by 15 with rounding toward minus infinity.
    function automatic logic [PHASE_W-1:0] phase_drive(input logic [POWER_W-1:0] power,
                                                        input int signed ang);
        longint signed prod;
        longint signed shifted;
        prod    = longint'(power) * longint'(angle_sine(ang));
        shifted = prod >>> 15;
        return shifted[PHASE_W-1:0];
    endfunction

    function automatic phase_triplet_t predict_phases(input logic [ANGLE_W-1:0] angle,
                                                      input logic [POWER_W-1:0] power);
        phase_triplet_t t;
        int signed      ang;
        ang = int'($signed(angle));
        t.phase_a = phase_drive(power, ang + PHASE_OFFSET);
        t.phase_b = phase_drive(power, ang);
        t.phase_c = phase_drive(power, ang - PHASE_OFFSET);
        return t;
    endfunction

    task automatic push_cmd(input int signed angle, input int unsigned power);
        drive_cmd_t c;
        c.angle = angle[ANGLE_W-1:0];
        c.power = power[POWER_W-1:0];
        cmd_queue.push_back(c);
    endtask

    // Angles on or one step beside quadrant edges, directly or after the phase offset.
    function automatic int signed edge_angle();
        int signed a;
        a = int'($urandom_range(0, 108)) * 300 - 16200 + int'($urandom_range(0, 2)) - 1;
        return a;
    endfunction

    function automatic int unsigned random_power();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            return $urandom_range(0, 65535);
        end else if (pick < 14) begin
            return 65535;
        end else if (pick < 15) begin
            return 0;
        end else begin
            return $urandom_range(0, 255);
        end
    endfunction

    // Source side: present queued commands with random gaps and record each transfer.
    always @(posedge i_clk) begin
        drive_cmd_t  c;
        logic [31:0] word;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap_left  <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_phases.push_back(predict_phases(s_axis_tdata[ANGLE_W-1:0],
                    s_axis_tdata[ANGLE_W +: POWER_W]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap_left > 0) begin
                    s_axis_tvalid <= 1'b0;
                    src_gap_left  <= src_gap_left - 1;
                end else if (cmd_queue.size() > 0) begin
                    c    = cmd_queue.pop_front();
                    word = {1'b0, c.power, c.angle};
                    s_axis_tdata  <= word[IN_DATA_W-1:0];
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 15) == 0) begin
                        src_steady <= ~src_steady;
                    end
                    src_gap_left <= src_steady ? 0 : $urandom_range(0, 3);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each transfer against the oldest prediction, then stall at random.
    always @(posedge i_clk) begin
        phase_triplet_t exp_t;
        phase_triplet_t got;
        int unsigned    wait_left;
        if (!i_rst_n) begin
            m_axis_tready   <= 1'b0;
            sink_stall_left <= 0;
        end else begin
            wait_left = sink_stall_left;
            if (m_axis_tvalid && m_axis_tready) begin
                got.phase_a = m_axis_tdata[0 +: PHASE_W];
                got.phase_b = m_axis_tdata[PHASE_W +: PHASE_W];
                got.phase_c = m_axis_tdata[2 * PHASE_W +: PHASE_W];
                if (expected_phases.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected transfer a=%0d b=%0d c=%0d", $realtime,
                            $signed(got.phase_a), $signed(got.phase_b), $signed(got.phase_c));
                    end
                end else begin
                    exp_t = expected_phases.pop_front();
                    if (got != exp_t) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display({"%0t: phase mismatch exp a=%0d b=%0d c=%0d",
                                " got a=%0d b=%0d c=%0d"},
                                $realtime, $signed(exp_t.phase_a), $signed(exp_t.phase_b),
                                $signed(exp_t.phase_c), $signed(got.phase_a),
                                $signed(got.phase_b), $signed(got.phase_c));
                        end
                    end
                end
                if ($urandom_range(0, 15) == 0) begin
                    sink_steady <= ~sink_steady;
                end
                wait_left = sink_steady ? 0 : $urandom_range(0, 3);
            end
            if (wait_left > 0) begin
                m_axis_tready   <= 1'b0;
                sink_stall_left <= wait_left - 1;
            end else begin
                m_axis_tready   <= 1'b1;
                sink_stall_left <= 0;
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        for (int i = 0; i <= QUARTER_STEPS; i++) begin
            quarter_sine[i] = quarter_sine_value(i);
        end

        // Directed commands: angle and power extremes, quadrant edges and offset wraps.
        push_cmd(0, 0);
        push_cmd(0, 65535);
        push_cmd(16383, 65535);
        push_cmd(-16384, 65535);
        push_cmd(-1, 65535);
        push_cmd(1, 1);
        push_cmd(900, 65535);
        push_cmd(1800, 65535);
        push_cmd(2700, 65535);
        push_cmd(3600, 65535);
        push_cmd(-900, 65535);
        push_cmd(-2700, 32768);
        push_cmd(300, 65535);
        push_cmd(1200, 65535);
        push_cmd(3000, 65535);
        push_cmd(-3000, 65535);
        push_cmd(600, 1);
        push_cmd(-600, 1);
        push_cmd(2100, 3);
        push_cmd(16383, 1);
        push_cmd(-16384, 1);
        push_cmd(-16200, 12345);
        push_cmd(16200, 54321);
        push_cmd(-1, 0);
        push_cmd(16383, 0);

        // Random commands, part of them pinned to quadrant edges.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if ($urandom_range(0, 9) < 7) begin
                push_cmd(int'($urandom_range(0, 32767)) - 16384, random_power());
            end else begin
                push_cmd(edge_angle(), random_power());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command has gone in and every triplet has come back.
        while (cmd_queue.size() > 0 || s_axis_tvalid || expected_phases.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
